// File: src/nths_pkg.sv
// nths_pkg: shared types and constants of the neighbor table block
// used by the table cells, the distance unit and the top level
package nths_pkg;

	localparam int ADDR_W   = 32;
	localparam int POS_W    = 24;
	localparam int SPEED_W  = 16;
	localparam int HEAD_W   = 12;
	localparam int EDGE_W   = 16;
	localparam int TIME_W   = 32;
	localparam int CFG_W    = 16;
	localparam int REQ_W    = 3;
	localparam int STAT_W   = 2;
	// distance: squares of 25-bit magnitudes, root of a 50-bit sum
	localparam int MAG_W    = POS_W + 1;
	localparam int SQ_W     = 2 * MAG_W;
	localparam int ROOT_W   = MAG_W;

	// request codes
	localparam logic [REQ_W-1:0] REQ_UPDATE = 3'd0;
	localparam logic [REQ_W-1:0] REQ_LOOKUP = 3'd1;
	localparam logic [REQ_W-1:0] REQ_ISNB   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_NEXT   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

	// status codes
	localparam logic [STAT_W-1:0] ST_HIT  = 2'd0;
	localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
	localparam logic [STAT_W-1:0] ST_DROP = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_LIFETIME = 2'd0;
	localparam logic [1:0] CFG_GOAL     = 2'd1;
	localparam logic [1:0] CFG_SEARCH   = 2'd2;
	localparam logic [1:0] CFG_REACH    = 2'd3;

	// cell operations
	localparam logic [2:0] OP_HOLD = 3'd0;
	localparam logic [2:0] OP_ROT  = 3'd1;
	localparam logic [2:0] OP_CMP  = 3'd2;
	localparam logic [2:0] OP_INS  = 3'd3;
	localparam logic [2:0] OP_EXP  = 3'd4;
	localparam logic [2:0] OP_CLR  = 3'd5;

	typedef struct packed {
		logic [ADDR_W-1:0]        addr;
		logic signed [POS_W-1:0]  x;
		logic signed [POS_W-1:0]  y;
		logic [SPEED_W-1:0]       speed;
		logic [HEAD_W-1:0]        heading;
		logic signed [EDGE_W-1:0] edge_no;
		logic [TIME_W-1:0]        expire;
	} slot_t;

	typedef struct packed {
		logic [2:0]        op;
		logic [TIME_W-1:0] now;
	} cell_ctl_t;

endpackage

// File: src/neighbor_table_next_hop_select_top.sv
// neighbor_table_next_hop_select_top: neighbor table with greedy next-hop choice
// depends on nths_pkg, nths_cell, nths_dist
//
// Requests are taken with start while busy is low; each gives one result word,
// shown for one cycle with done. The table is a chain of TABLE_DEPTH slot cells
// kept newest first. Table passes move the chain one slot per cycle, a next-hop
// scan pausing while distances run: a lookup or refresh rotates it once round, a
// purge marks expired slots and then closes the gaps, and an insert shifts the
// chain down and writes the new slot at the head. A next hop computes its own
// distance to the target and then, per slot on an allowed edge, two distances
// in the bit-serial square root units; other slots are rotated past.
module neighbor_table_next_hop_select_top #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic [2:0]  req_type,
	input  logic [31:0] now_time,
	input  logic [31:0] node_addr,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic [15:0] speed,
	input  logic [11:0] heading,
	input  logic signed [15:0] edge_id,
	input  logic signed [15:0] edge_alt,
	input  logic signed [15:0] edge_third,
	input  logic signed [23:0] target_x,
	input  logic signed [23:0] target_y,
	output logic [1:0]  status,
	output logic [31:0] hop_addr,
	output logic signed [23:0] nb_x,
	output logic signed [23:0] nb_y,
	output logic [15:0] nb_speed,
	output logic [11:0] nb_heading,
	output logic signed [15:0] nb_edge,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_data
);
	import nths_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_UROT = 4'd1;
	localparam logic [3:0] S_UCHK = 4'd2;
	localparam logic [3:0] S_EXP  = 4'd3;
	localparam logic [3:0] S_CMP  = 4'd4;
	localparam logic [3:0] S_INS  = 4'd5;
	localparam logic [3:0] S_LROT = 4'd6;
	localparam logic [3:0] S_OWN  = 4'd7;
	localparam logic [3:0] S_OWNW = 4'd8;
	localparam logic [3:0] S_SCAN = 4'd9;
	localparam logic [3:0] S_WAIT = 4'd10;
	localparam logic [3:0] S_CLR  = 4'd11;
	localparam logic [3:0] S_DONE = 4'd12;

	logic [3:0]  state_q;
	logic [CW-1:0] cnt_q;
	logic        found_q;

	logic [CFG_W-1:0] life_q, goal_q, search_q, reach_q;

	// latched request
	logic [REQ_W-1:0] req_q;
	logic [TIME_W-1:0] now_q, exp_q;
	logic [ADDR_W-1:0] addr_q;
	logic signed [POS_W-1:0] px_q, py_q, tx_q, ty_q;
	logic [SPEED_W-1:0] spd_q;
	logic [HEAD_W-1:0]  head_q;
	logic signed [EDGE_W-1:0] e1_q, e2_q, e3_q;

	logic [ROOT_W-1:0] own_q, best_q;

	// result word
	logic [STAT_W-1:0] res_st_q;
	slot_t             res_q;

	// chain wiring
	slot_t ent_w [TABLE_DEPTH];
	logic  vld_w [TABLE_DEPTH];
	logic  hole_w [TABLE_DEPTH+1];
	slot_t new_ent, wrap_ent, c0, c0_mod;
	logic  wrap_vld;
	cell_ctl_t ctl;
	logic [2:0] cop;

	logic a_go, b_go, a_done, b_done;
	logic signed [POS_W-1:0] a_bx, a_by;
	logic [ROOT_W-1:0] a_root, b_root, dev;
	logic edge_ok, elig, umatch, lmatch, take;
	logic [32:0] exp_sum;

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_DONE;
	assign status     = res_st_q;
	assign hop_addr   = res_q.addr;
	assign nb_x       = res_q.x;
	assign nb_y       = res_q.y;
	assign nb_speed   = res_q.speed;
	assign nb_heading = res_q.heading;
	assign nb_edge    = res_q.edge_no;

	assign c0 = ent_w[0];
	assign exp_sum = {1'b0, now_time} + 33'(life_q);

	// entry written by an update
	always_comb begin
		new_ent.addr    = addr_q;
		new_ent.x       = px_q;
		new_ent.y       = py_q;
		new_ent.speed   = spd_q;
		new_ent.heading = head_q;
		new_ent.edge_no = e1_q;
		new_ent.expire  = exp_q;
		c0_mod = new_ent;
		c0_mod.addr   = c0.addr;
		c0_mod.expire = (exp_q > c0.expire) ? exp_q : c0.expire;
	end

	// slot at the head of the chain against the request
	assign umatch  = vld_w[0] && (c0.addr == addr_q) && !found_q;
	assign lmatch  = umatch;
	assign edge_ok = (c0.edge_no == e1_q) ||
		((e2_q != -16'sd1) && (c0.edge_no == e2_q)) || (c0.edge_no == e3_q);
	assign elig    = vld_w[0] && edge_ok;
	assign dev     = (a_root > ROOT_W'(goal_q)) ? a_root - ROOT_W'(goal_q)
		: ROOT_W'(goal_q) - a_root;
	assign take    = (dev < best_q) && (b_root < own_q) && (a_root < ROOT_W'(reach_q));

	// cell operation and distance starts per state
	always_comb begin
		cop  = OP_HOLD;
		a_go = 1'b0;
		b_go = 1'b0;
		case (state_q)
			S_UROT, S_LROT: cop = OP_ROT;
			S_EXP: cop = OP_EXP;
			S_CMP: cop = OP_CMP;
			S_INS: cop = OP_INS;
			S_CLR: cop = OP_CLR;
			// both units start so they stay in step; only the hop unit is used
			S_OWN: begin
				a_go = 1'b1;
				b_go = 1'b1;
			end
			S_SCAN: begin
				if (cnt_q != CW'(TABLE_DEPTH)) begin
					if (elig) begin
						a_go = 1'b1;
						b_go = 1'b1;
					end else begin
						cop = OP_ROT;
					end
				end
			end
			S_WAIT: if (a_done) cop = OP_ROT;
			default: cop = OP_HOLD;
		endcase
	end

	assign ctl.op  = cop;
	assign ctl.now = now_q;

	// rotation feeds the head slot back to the tail, refreshed on an update hit
	assign wrap_ent = (state_q == S_UROT && umatch) ? c0_mod : c0;
	assign wrap_vld = (cop == OP_ROT) ? vld_w[0] : 1'b0;
	assign hole_w[0] = 1'b0;

	// the chain of table cells
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		slot_t up_e, dn_e;
		logic  up_v, dn_v;
		if (i == 0) begin : g_head
			assign up_e = new_ent;
			assign up_v = 1'b1;
		end else begin : g_mid
			assign up_e = ent_w[i-1];
			assign up_v = vld_w[i-1];
		end
		if (i == TABLE_DEPTH - 1) begin : g_tail
			assign dn_e = wrap_ent;
			assign dn_v = wrap_vld;
		end else begin : g_body
			assign dn_e = ent_w[i+1];
			assign dn_v = vld_w[i+1];
		end
		nths_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.up_ent   (up_e),
			.up_vld   (up_v),
			.dn_ent   (dn_e),
			.dn_vld   (dn_v),
			.hole_in  (hole_w[i]),
			.ent      (ent_w[i]),
			.vld      (vld_w[i]),
			.hole_out (hole_w[i+1])
		);
	end

	// hop distance (own distance to the target first)
	assign a_bx = (state_q == S_OWN) ? tx_q : c0.x;
	assign a_by = (state_q == S_OWN) ? ty_q : c0.y;

	nths_dist u_dist_hop (
		.clk (clk), .arst_n (arst_n), .go (a_go),
		.ax (px_q), .ay (py_q), .bx (a_bx), .by (a_by),
		.root (a_root), .done (a_done)
	);

	// slot distance to the target
	nths_dist u_dist_tgt (
		.clk (clk), .arst_n (arst_n), .go (b_go),
		.ax (tx_q), .ay (ty_q), .bx (c0.x), .by (c0.y),
		.root (b_root), .done (b_done)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			life_q   <= 16'd2000;
			goal_q   <= 16'd1560;
			search_q <= 16'd1600;
			reach_q  <= 16'd1600;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_LIFETIME: life_q   <= cfg_data;
				CFG_GOAL:     goal_q   <= cfg_data;
				CFG_SEARCH:   search_q <= cfg_data;
				CFG_REACH:    reach_q  <= cfg_data;
				default:      life_q   <= life_q;
			endcase
		end
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					cnt_q   <= '0;
					found_q <= 1'b0;
					if (start) begin
						case (req_type)
							REQ_UPDATE: state_q <= S_UROT;
							REQ_LOOKUP, REQ_ISNB, REQ_NEXT: state_q <= S_EXP;
							REQ_CLEAR: state_q <= S_CLR;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_UROT, S_LROT: begin
					if (umatch) found_q <= 1'b1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(TABLE_DEPTH - 1)) begin
						cnt_q   <= '0;
						state_q <= (state_q == S_UROT) ? S_UCHK : S_DONE;
					end
				end
				S_UCHK: state_q <= found_q ? S_DONE : S_EXP;
				S_EXP: begin
					cnt_q   <= '0;
					state_q <= S_CMP;
				end
				S_CMP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(TABLE_DEPTH - 1)) begin
						cnt_q <= '0;
						case (req_q)
							REQ_UPDATE: state_q <= S_INS;
							REQ_NEXT:   state_q <= S_OWN;
							default:    state_q <= S_LROT;
						endcase
					end
				end
				S_INS: state_q <= S_DONE;
				S_OWN: state_q <= S_OWNW;
				S_OWNW: if (a_done) state_q <= S_SCAN;
				S_SCAN: begin
					if (cnt_q == CW'(TABLE_DEPTH)) begin
						state_q <= S_DONE;
					end else if (elig) begin
						state_q <= S_WAIT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_WAIT: begin
					if (a_done) begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_CLR: state_q <= S_DONE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request latch and result word
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q  <= req_type;
			now_q  <= now_time;
			exp_q  <= exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
			addr_q <= node_addr;
			px_q   <= pos_x;
			py_q   <= pos_y;
			spd_q  <= speed;
			head_q <= heading;
			e1_q   <= edge_id;
			e2_q   <= edge_alt;
			e3_q   <= edge_third;
			tx_q   <= target_x;
			ty_q   <= target_y;
			best_q <= ROOT_W'(search_q);
			res_q  <= '0;
			res_st_q <= (req_type == REQ_CLEAR) ? ST_HIT : ST_MISS;
		end
		case (state_q)
			S_UROT: begin
				if (umatch) begin
					res_q    <= c0_mod;
					res_st_q <= ST_HIT;
				end
			end
			S_LROT: begin
				if (lmatch) begin
					res_q    <= c0;
					res_st_q <= ST_HIT;
				end
			end
			S_INS: begin
				res_q    <= new_ent;
				res_st_q <= vld_w[TABLE_DEPTH-1] ? ST_DROP : ST_HIT;
			end
			S_OWNW: if (a_done) own_q <= a_root;
			S_WAIT: begin
				if (a_done && take) begin
					best_q   <= dev;
					res_q    <= c0;
					res_st_q <= ST_HIT;
				end
			end
			// the expiry is not part of the result word
			S_DONE: res_q.expire <= '0;
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	// the two distance units run in lockstep
	a_dist_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		a_done == b_done) else $error("distance units out of step");

	// a result word ends the request
	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after result word");

	// an accepted request makes the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("request not taken");

	// table stays compact after a purge
	a_compact: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP && cnt_q == CW'(TABLE_DEPTH - 1)) |=>
		(!vld_w[TABLE_DEPTH-1] || vld_w[0])) else $error("table not compact");
`endif

endmodule

// File: src/nths_cell.sv
// nths_cell: one table slot of the neighbor chain
// depends on nths_pkg (slot_t, cell_ctl_t, cell operations)
module nths_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  nths_pkg::cell_ctl_t ctl,
	input  nths_pkg::slot_t    up_ent,
	input  logic               up_vld,
	input  nths_pkg::slot_t    dn_ent,
	input  logic               dn_vld,
	input  logic               hole_in,
	output nths_pkg::slot_t    ent,
	output logic               vld,
	output logic               hole_out
);
	import nths_pkg::*;

	slot_t ent_q;
	logic  vld_q;
	logic  hole;

	// a gap at or before this slot pulls the next slot up during compaction
	assign hole     = hole_in | ~vld_q;
	assign hole_out = hole;
	assign ent      = ent_q;
	assign vld      = vld_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			case (ctl.op)
				OP_ROT: vld_q <= dn_vld;
				OP_CMP: if (hole) vld_q <= dn_vld;
				OP_INS: vld_q <= up_vld;
				OP_EXP: if (ent_q.expire < ctl.now) vld_q <= 1'b0;
				OP_CLR: vld_q <= 1'b0;
				default: vld_q <= vld_q;
			endcase
		end
	end

	// slot payload
	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_ROT: ent_q <= dn_ent;
			OP_CMP: if (hole) ent_q <= dn_ent;
			OP_INS: ent_q <= up_ent;
			default: ent_q <= ent_q;
		endcase
	end

endmodule

// File: src/nths_isqrt.sv
// nths_isqrt: bit-serial integer square root, one result bit per cycle
// depends on nths_pkg (SQ_W, ROOT_W)
module nths_isqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  logic [nths_pkg::SQ_W-1:0]    op,
	output logic [nths_pkg::ROOT_W-1:0]  root,
	output logic                         done
);
	import nths_pkg::*;

	localparam int CNT_W = $clog2(ROOT_W + 1);
	localparam int REM_W = ROOT_W + 2;

	logic [SQ_W-1:0]   op_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [REM_W-1:0]  rem_n;
	logic [REM_W-1:0]  trial;
	logic              fit;

	// bring down two bits, try root*4+1
	assign rem_n = {rem_q[REM_W-3:0], op_q[SQ_W-1 -: 2]};
	assign trial = {root_q, 2'b01};
	assign fit   = rem_n >= trial;
	assign root  = root_q;
	assign done  = done_q;

	// step counter and done strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q <= CNT_W'(ROOT_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) done_q <= 1'b1;
			end
		end
	end

	// remainder and root
	always_ff @(posedge clk) begin
		if (go) begin
			op_q   <= op;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			op_q   <= {op_q[SQ_W-3:0], 2'b00};
			rem_q  <= fit ? rem_n - trial : rem_n;
			root_q <= {root_q[ROOT_W-2:0], fit};
		end
	end

endmodule

// File: src/nths_dist.sv
// nths_dist: euclidean distance floor(sqrt(dx^2+dy^2)) between two points
// depends on nths_pkg and nths_isqrt
module nths_dist (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              go,
	input  logic signed [nths_pkg::POS_W-1:0] ax,
	input  logic signed [nths_pkg::POS_W-1:0] ay,
	input  logic signed [nths_pkg::POS_W-1:0] bx,
	input  logic signed [nths_pkg::POS_W-1:0] by,
	output logic [nths_pkg::ROOT_W-1:0]       root,
	output logic                              done
);
	import nths_pkg::*;

	logic signed [MAG_W-1:0] dx, dy;
	logic [MAG_W-1:0] mx_s1, my_s1;
	logic [SQ_W-1:0]  sx_s2, sy_s2;
	logic             v_s1, v_s2;

	assign dx = MAG_W'(ax) - MAG_W'(bx);
	assign dy = MAG_W'(ay) - MAG_W'(by);

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= go;
			v_s2 <= v_s1;
		end
	end

	// magnitudes, then squares
	always_ff @(posedge clk) begin
		mx_s1 <= dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
		my_s1 <= dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
		sx_s2 <= SQ_W'(mx_s1) * SQ_W'(mx_s1);
		sy_s2 <= SQ_W'(my_s1) * SQ_W'(my_s1);
	end

	nths_isqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (v_s2),
		.op     (sx_s2 + sy_s2),
		.root   (root),
		.done   (done)
	);

endmodule
